// ===== sv/bfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types and constants of the flocking steering block: the stored agent
// record, the arithmetic unit opcodes and its request and response bundles.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int MAX_AGENTS_DEF = 64;
    localparam int IDX_W          = 6;
    localparam int GAIN_W         = 16;
    localparam int RAD_W          = 31;

    typedef struct packed {
        logic [31:0]         pos_x;
        logic [31:0]         pos_y;
        logic [31:0]         vel_x;
        logic [31:0]         vel_y;
        logic [RAD_W-1:0]    sense_radius;
        logic [RAD_W-1:0]    avoid_radius;
        logic [3*GAIN_W-1:0] gains;
        logic [RAD_W-1:0]    move_speed;
    } agent_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic        start;
        alu_op_t     op;
        logic [63:0] opa;
        logic [31:0] opb;
    } alu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } alu_rsp_t;

endpackage

// ===== sv/bfs_if.sv =====
// ----------------------------------------------------------------------------
// bfs channel interfaces
// Valid/ready channels for agent items (input) and steering results (output).
// ----------------------------------------------------------------------------
interface bfs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        sense_radius;
    logic [30:0]        avoid_radius;
    logic [15:0]        cohesion_gain;
    logic [15:0]        alignment_gain;
    logic [15:0]        avoid_gain;
    logic [30:0]        move_speed;
    logic               last_agent;

    modport source (
        output valid, pos_x, pos_y, vel_x, vel_y, sense_radius, avoid_radius,
               cohesion_gain, alignment_gain, avoid_gain, move_speed, last_agent,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, vel_x, vel_y, sense_radius, avoid_radius,
               cohesion_gain, alignment_gain, avoid_gain, move_speed, last_agent,
        output ready
    );
endinterface

interface bfs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic [5:0]         agent_index;
    logic               last_result;

    modport source (
        output valid, accel_x, accel_y, agent_index, last_result,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, agent_index, last_result,
        output ready
    );
endinterface

// ===== sv/bfs_store.sv =====
// ----------------------------------------------------------------------------
// bfs_store
// Agent record memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfs_store #(
    parameter int MAX_AGENTS = bfs_pkg::MAX_AGENTS_DEF,
    parameter int AW         = $clog2(MAX_AGENTS)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bfs_pkg::agent_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output bfs_pkg::agent_t rd_data
);
    import bfs_pkg::*;

    agent_t mem [MAX_AGENTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/bfs_alu.sv =====
// ----------------------------------------------------------------------------
// bfs_alu
// Shared arithmetic unit: registered 32x32 multiply, 62/32 restoring divide
// (31 quotient bits) and 64-bit integer square root, both one bit per cycle
// over a single compare/subtract path.
// ----------------------------------------------------------------------------
module bfs_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  bfs_pkg::alu_req_t req,
    output bfs_pkg::alu_rsp_t rsp
);
    import bfs_pkg::*;

    localparam logic [5:0] DIV_STEPS  = 6'd31;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    logic        busy_reg;
    logic        done_reg;
    alu_op_t     op_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [63:0] src_reg;
    logic [31:0] div_reg;
    logic [63:0] res_reg;

    logic [33:0] cmp_a;
    logic [33:0] cmp_b;
    logic [34:0] diff;
    logic        ge;

    // one trial subtract serves both divide and square root
    always_comb
    begin
        case (op_reg)
            ALU_SQRT:
            begin
                cmp_a = {rem_reg[31:0], src_reg[63:62]};
                cmp_b = {res_reg[31:0], 2'b01};
            end
            default:
            begin
                cmp_a = {1'b0, rem_reg[31:0], src_reg[63]};
                cmp_b = {2'b00, div_reg};
            end
        endcase
        diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        ge   = !diff[34];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg <= req.op;
                case (req.op)
                    ALU_MUL:
                    begin
                        res_reg  <= {32'd0, req.opa[31:0]} * {32'd0, req.opb};
                        done_reg <= 1'b1;
                    end
                    ALU_DIV:
                    begin
                        rem_reg  <= {3'b000, req.opa[61:31]};
                        src_reg  <= {req.opa[30:0], 33'd0};
                        div_reg  <= req.opb;
                        res_reg  <= '0;
                        cnt_reg  <= DIV_STEPS;
                        busy_reg <= 1'b1;
                    end
                    ALU_SQRT:
                    begin
                        rem_reg  <= '0;
                        src_reg  <= req.opa;
                        res_reg  <= '0;
                        cnt_reg  <= SQRT_STEPS;
                        busy_reg <= 1'b1;
                    end
                    default:
                    begin
                        done_reg <= 1'b1;
                    end
                endcase
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[33:0] : cmp_a;
                res_reg <= {res_reg[62:0], ge};
                src_reg <= (op_reg == ALU_SQRT) ? (src_reg << 2) : (src_reg << 1);
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ===== sv/bfs_seq.sv =====
// ----------------------------------------------------------------------------
// bfs_seq
// Sequencer: loads agents, then walks every agent pair and the three steering
// terms, issuing multiply, divide and square root steps to the shared unit.
// ----------------------------------------------------------------------------
module bfs_seq #(
    parameter int MAX_AGENTS = bfs_pkg::MAX_AGENTS_DEF,
    parameter int AW         = $clog2(MAX_AGENTS),
    parameter int CW         = $clog2(MAX_AGENTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    bfs_in_if.sink            in_ch,
    bfs_out_if.source         out_ch,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output bfs_pkg::agent_t   wr_data,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  bfs_pkg::agent_t   rd_data,
    output bfs_pkg::alu_req_t alu_req,
    input  bfs_pkg::alu_rsp_t alu_rsp
);
    import bfs_pkg::*;

    localparam int ACC_W = 40;
    localparam int SUM_W = 43;

    typedef enum logic [4:0] {
        S_IDLE, S_AI_RD, S_AI_LAT, S_SR2, S_J_CHK, S_J_LAT, S_SQX, S_SQY, S_NB,
        S_DIST, S_FALL, S_UNIT, S_SMUL, S_T_SEL, S_T_SHIFT, S_T_SQX, S_T_SQY,
        S_T_LEN, S_T_K, S_T_UNIT, S_T_PH, S_T_PL, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        TERM_COH, TERM_ALI, TERM_SEP, TERM_END
    } term_t;

    state_t                  state_reg;
    term_t                   term_reg;
    logic                    wait_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           n_reg;
    logic [CW-1:0]           i_reg;
    logic [CW-1:0]           j_reg;

    logic signed [31:0]      px_reg;
    logic signed [31:0]      py_reg;
    logic [RAD_W-1:0]        sr_reg;
    logic [RAD_W-1:0]        ar_reg;
    logic [3*GAIN_W-1:0]     gains_reg;
    logic [RAD_W-1:0]        spd_reg;
    logic [63:0]             sr2_reg;

    logic signed [32:0]      dx_reg;
    logic signed [32:0]      dy_reg;
    logic signed [31:0]      vxj_reg;
    logic signed [31:0]      vyj_reg;
    logic [ACC_W-1:0]        magx_reg;
    logic [ACC_W-1:0]        magy_reg;
    logic                    negx_reg;
    logic                    negy_reg;
    logic [63:0]             sq_reg;
    logic [64:0]             lo_reg;
    logic [31:0]             d_reg;
    logic [30:0]             f_reg;
    logic [30:0]             u_reg;
    logic                    comp_reg;
    logic [46:0]             k_reg;
    logic [47:0]             p1_reg;

    logic signed [ACC_W-1:0] cx_reg;
    logic signed [ACC_W-1:0] cy_reg;
    logic signed [ACC_W-1:0] lx_reg;
    logic signed [ACC_W-1:0] ly_reg;
    logic signed [ACC_W-1:0] sx_reg;
    logic signed [ACC_W-1:0] sy_reg;
    logic                    nb_reg;
    logic signed [SUM_W-1:0] ax_reg;
    logic signed [SUM_W-1:0] ay_reg;

    logic                    out_valid_reg;
    logic [31:0]             out_ax_reg;
    logic [31:0]             out_ay_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic                    out_last_reg;

    logic                    step_done;
    logic                    in_xfer;
    logic                    room;
    logic signed [32:0]      dx_c;
    logic signed [32:0]      dy_c;
    logic [32:0]             mdx_c;
    logic [32:0]             mdy_c;
    logic signed [ACC_W-1:0] vsel_x;
    logic signed [ACC_W-1:0] vsel_y;
    logic [ACC_W-1:0]        mvx_c;
    logic [ACC_W-1:0]        mvy_c;
    logic [GAIN_W-1:0]       gain_sel;
    logic [30:0]             m_sel;
    logic [30:0]             cm_c;
    logic [48:0]             tsum_c;
    logic [40:0]             tval_c;
    logic                    neg_sel;

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [31:0] r;
        if (v > SUM_W'(64'sd2147483647))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -SUM_W'(64'sd2147483648))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign step_done = wait_reg && alu_rsp.done;
    assign room      = count_reg < CW'(MAX_AGENTS);
    assign in_xfer   = in_ch.valid && in_ch.ready;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign wr_en       = in_xfer && room;
    assign wr_addr     = count_reg[AW-1:0];
    assign wr_data     = '{pos_x:        in_ch.pos_x,
                           pos_y:        in_ch.pos_y,
                           vel_x:        in_ch.vel_x,
                           vel_y:        in_ch.vel_y,
                           sense_radius: in_ch.sense_radius,
                           avoid_radius: in_ch.avoid_radius,
                           gains:        {in_ch.avoid_gain, in_ch.alignment_gain,
                                          in_ch.cohesion_gain},
                           move_speed:   in_ch.move_speed};

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.accel_x     = out_ax_reg;
    assign out_ch.accel_y     = out_ay_reg;
    assign out_ch.agent_index = out_idx_reg;
    assign out_ch.last_result = out_last_reg;

    // pair offsets straight off the read port
    assign dx_c  = $signed({rd_data.pos_x[31], rd_data.pos_x}) - $signed({px_reg[31], px_reg});
    assign dy_c  = $signed({rd_data.pos_y[31], rd_data.pos_y}) - $signed({py_reg[31], py_reg});
    assign mdx_c = dx_c[32] ? -dx_c : dx_c;
    assign mdy_c = dy_c[32] ? -dy_c : dy_c;

    always_comb
    begin
        case (term_reg)
            TERM_COH:
            begin
                vsel_x   = cx_reg;
                vsel_y   = cy_reg;
                gain_sel = gains_reg[GAIN_W-1:0];
            end
            TERM_ALI:
            begin
                vsel_x   = lx_reg;
                vsel_y   = ly_reg;
                gain_sel = gains_reg[2*GAIN_W-1:GAIN_W];
            end
            default:
            begin
                vsel_x   = sx_reg;
                vsel_y   = sy_reg;
                gain_sel = gains_reg[3*GAIN_W-1:2*GAIN_W];
            end
        endcase
        mvx_c   = vsel_x[ACC_W-1] ? -vsel_x : vsel_x;
        mvy_c   = vsel_y[ACC_W-1] ? -vsel_y : vsel_y;
        m_sel   = comp_reg ? magy_reg[30:0] : magx_reg[30:0];
        neg_sel = comp_reg ? negy_reg : negx_reg;
        cm_c    = alu_rsp.result[60:30];
        tsum_c  = {1'b0, p1_reg} + {18'd0, alu_rsp.result[60:30]};
        tval_c  = tsum_c[48:8];
    end

    always_comb
    begin
        alu_req = '0;
        rd_en   = 1'b0;
        rd_addr = i_reg[AW-1:0];
        case (state_reg)
            S_AI_RD:
            begin
                rd_en = 1'b1;
            end
            S_J_CHK:
            begin
                rd_en   = (j_reg != n_reg) && (j_reg != i_reg);
                rd_addr = j_reg[AW-1:0];
            end
            S_SR2:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {33'd0, sr_reg};
                alu_req.opb = {1'b0, sr_reg};
            end
            S_SQX, S_T_SQX:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {32'd0, magx_reg[31:0]};
                alu_req.opb = magx_reg[31:0];
            end
            S_SQY, S_T_SQY:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {32'd0, magy_reg[31:0]};
                alu_req.opb = magy_reg[31:0];
            end
            S_DIST, S_T_LEN:
            begin
                alu_req.op  = ALU_SQRT;
                alu_req.opa = lo_reg[63:0];
            end
            S_FALL:
            begin
                alu_req.op  = ALU_DIV;
                alu_req.opa = {3'b000, ar_reg - d_reg[30:0], 30'd0};
                alu_req.opb = {1'b0, ar_reg};
            end
            S_UNIT, S_T_UNIT:
            begin
                alu_req.op  = ALU_DIV;
                alu_req.opa = {3'b000, m_sel, 30'd0};
                alu_req.opb = d_reg;
            end
            S_SMUL:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {33'd0, u_reg};
                alu_req.opb = {1'b0, f_reg};
            end
            S_T_K:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {48'd0, gain_sel};
                alu_req.opb = {1'b0, spd_reg};
            end
            S_T_PH:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {47'd0, k_reg[46:30]};
                alu_req.opb = {1'b0, u_reg};
            end
            S_T_PL:
            begin
                alu_req.op  = ALU_MUL;
                alu_req.opa = {34'd0, k_reg[29:0]};
                alu_req.opb = {1'b0, u_reg};
            end
            default:
            begin
                alu_req.op = ALU_MUL;
            end
        endcase
        alu_req.start = !wait_reg && (state_reg inside {S_SR2, S_SQX, S_SQY, S_DIST,
            S_FALL, S_UNIT, S_SMUL, S_T_SQX, S_T_SQY, S_T_LEN, S_T_K, S_T_UNIT,
            S_T_PH, S_T_PL});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (alu_req.start)
            begin
                wait_reg <= 1'b1;
            end
            if (step_done)
            begin
                wait_reg <= 1'b0;
            end
            // S_FIN reloads the result register itself
            if (out_ch.valid && out_ch.ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        if (in_ch.last_agent)
                        begin
                            n_reg     <= room ? count_reg + CW'(1) : count_reg;
                            count_reg <= '0;
                            i_reg     <= '0;
                            state_reg <= S_AI_RD;
                        end
                        else if (room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                    end
                end
                S_AI_RD:
                begin
                    state_reg <= S_AI_LAT;
                end
                S_AI_LAT:
                begin
                    px_reg    <= $signed(rd_data.pos_x);
                    py_reg    <= $signed(rd_data.pos_y);
                    sr_reg    <= rd_data.sense_radius;
                    ar_reg    <= rd_data.avoid_radius;
                    gains_reg <= rd_data.gains;
                    spd_reg   <= rd_data.move_speed;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    lx_reg    <= '0;
                    ly_reg    <= '0;
                    sx_reg    <= '0;
                    sy_reg    <= '0;
                    ax_reg    <= '0;
                    ay_reg    <= '0;
                    nb_reg    <= 1'b0;
                    j_reg     <= '0;
                    state_reg <= S_SR2;
                end
                S_SR2:
                begin
                    if (step_done)
                    begin
                        sr2_reg   <= alu_rsp.result;
                        state_reg <= S_J_CHK;
                    end
                end
                S_J_CHK:
                begin
                    if (j_reg == n_reg)
                    begin
                        term_reg  <= TERM_COH;
                        state_reg <= S_T_SEL;
                    end
                    else if (j_reg == i_reg)
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_J_LAT;
                    end
                end
                S_J_LAT:
                begin
                    dx_reg    <= dx_c;
                    dy_reg    <= dy_c;
                    vxj_reg   <= $signed(rd_data.vel_x);
                    vyj_reg   <= $signed(rd_data.vel_y);
                    magx_reg  <= ACC_W'(mdx_c);
                    magy_reg  <= ACC_W'(mdy_c);
                    negx_reg  <= dx_c[32];
                    negy_reg  <= dy_c[32];
                    state_reg <= S_SQX;
                end
                S_SQX, S_T_SQX:
                begin
                    if (step_done)
                    begin
                        sq_reg    <= alu_rsp.result;
                        state_reg <= (state_reg == S_SQX) ? S_SQY : S_T_SQY;
                    end
                end
                S_SQY, S_T_SQY:
                begin
                    if (step_done)
                    begin
                        lo_reg    <= {1'b0, sq_reg} + {1'b0, alu_rsp.result};
                        state_reg <= (state_reg == S_SQY) ? S_NB : S_T_LEN;
                    end
                end
                S_NB:
                begin
                    // coincident, out of range or overflowing squares are skipped
                    if (lo_reg == '0 || lo_reg > {1'b0, sr2_reg})
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_J_CHK;
                    end
                    else
                    begin
                        cx_reg    <= cx_reg + ACC_W'(dx_reg);
                        cy_reg    <= cy_reg + ACC_W'(dy_reg);
                        lx_reg    <= lx_reg + ACC_W'(vxj_reg);
                        ly_reg    <= ly_reg + ACC_W'(vyj_reg);
                        nb_reg    <= 1'b1;
                        state_reg <= S_DIST;
                    end
                end
                S_DIST:
                begin
                    if (step_done)
                    begin
                        d_reg <= alu_rsp.result[31:0];
                        if (alu_rsp.result[31:0] < {1'b0, ar_reg})
                        begin
                            state_reg <= S_FALL;
                        end
                        else
                        begin
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= S_J_CHK;
                        end
                    end
                end
                S_FALL:
                begin
                    if (step_done)
                    begin
                        f_reg     <= alu_rsp.result[30:0];
                        comp_reg  <= 1'b0;
                        state_reg <= S_UNIT;
                    end
                end
                S_UNIT:
                begin
                    if (step_done)
                    begin
                        u_reg     <= alu_rsp.result[30:0];
                        state_reg <= S_SMUL;
                    end
                end
                S_SMUL:
                begin
                    if (step_done)
                    begin
                        // push away from the neighbour
                        if (!comp_reg)
                        begin
                            sx_reg    <= negx_reg ? sx_reg + ACC_W'(cm_c) : sx_reg - ACC_W'(cm_c);
                            comp_reg  <= 1'b1;
                            state_reg <= S_UNIT;
                        end
                        else
                        begin
                            sy_reg    <= negy_reg ? sy_reg + ACC_W'(cm_c) : sy_reg - ACC_W'(cm_c);
                            j_reg     <= j_reg + CW'(1);
                            state_reg <= S_J_CHK;
                        end
                    end
                end
                S_T_SEL:
                begin
                    if (term_reg == TERM_END)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if ((term_reg != TERM_SEP && !nb_reg) ||
                             (vsel_x == '0 && vsel_y == '0))
                    begin
                        term_reg <= term_t'(term_reg + 2'd1);
                    end
                    else
                    begin
                        magx_reg  <= mvx_c;
                        magy_reg  <= mvy_c;
                        negx_reg  <= vsel_x[ACC_W-1];
                        negy_reg  <= vsel_y[ACC_W-1];
                        state_reg <= S_T_SHIFT;
                    end
                end
                S_T_SHIFT:
                begin
                    // halve both until each fits in 31 bits
                    if (magx_reg[ACC_W-1:31] != '0 || magy_reg[ACC_W-1:31] != '0)
                    begin
                        magx_reg <= magx_reg >> 1;
                        magy_reg <= magy_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= S_T_SQX;
                    end
                end
                S_T_LEN:
                begin
                    if (step_done)
                    begin
                        d_reg     <= alu_rsp.result[31:0];
                        state_reg <= S_T_K;
                    end
                end
                S_T_K:
                begin
                    if (step_done)
                    begin
                        k_reg     <= alu_rsp.result[46:0];
                        comp_reg  <= 1'b0;
                        state_reg <= S_T_UNIT;
                    end
                end
                S_T_UNIT:
                begin
                    if (step_done)
                    begin
                        u_reg     <= alu_rsp.result[30:0];
                        state_reg <= S_T_PH;
                    end
                end
                S_T_PH:
                begin
                    if (step_done)
                    begin
                        p1_reg    <= alu_rsp.result[47:0];
                        state_reg <= S_T_PL;
                    end
                end
                S_T_PL:
                begin
                    if (step_done)
                    begin
                        if (!comp_reg)
                        begin
                            ax_reg    <= neg_sel ? ax_reg - $signed({2'b00, tval_c})
                                                 : ax_reg + $signed({2'b00, tval_c});
                            comp_reg  <= 1'b1;
                            state_reg <= S_T_UNIT;
                        end
                        else
                        begin
                            ay_reg    <= neg_sel ? ay_reg - $signed({2'b00, tval_c})
                                                 : ay_reg + $signed({2'b00, tval_c});
                            term_reg  <= term_t'(term_reg + 2'd1);
                            state_reg <= S_T_SEL;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ax_reg    <= sat32(ax_reg);
                        out_ay_reg    <= sat32(ay_reg);
                        out_idx_reg   <= IDX_W'(i_reg[AW-1:0]);
                        out_last_reg  <= (i_reg + CW'(1)) == n_reg;
                        if ((i_reg + CW'(1)) == n_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + CW'(1);
                            state_reg <= S_AI_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wait_reg)
        else $error("arithmetic step pending while loading");
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> wait_reg)
        else $error("unit finished a step that was not requested");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_AGENTS))
        else $error("agent count beyond store depth");
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg < n_reg && n_reg != '0))
        else $error("agent index outside frame");
`endif

endmodule

// ===== sv/boids_flocking_steering.sv =====
// ----------------------------------------------------------------------------
// boids_flocking_steering
// Flocking steering accelerations (cohesion, alignment, separation) per agent.
// ----------------------------------------------------------------------------
// in_ch carries one agent per transfer; agents are stored in load order while
// ready is high. A transfer with last_agent set closes the frame: ready drops
// and the block emits one acceleration per stored agent on out_ch, in load
// order, with last_result on the final one. Agents beyond MAX_AGENTS are
// dropped, but a last_agent on such a transfer still closes the frame.
// All arithmetic runs through one shared unit (multiply, divide and square
// root) under the sequencer, so per agent i it visits every other agent,
// with extra steps for each neighbor and more for each neighbor inside the
// avoidance radius, then works out the three terms: the work per frame grows
// with the number of agent pairs, n * (n - 1).
// The result register lets the next agent compute while a result waits; if
// the receiver stalls, the sequencer holds at the end of the next agent.
// After the last result is loaded ready rises again for the next frame.
// Reset clears the agent count and all handshake state; no clearing pass.
// ----------------------------------------------------------------------------
module boids_flocking_steering #(
    parameter int MAX_AGENTS = bfs_pkg::MAX_AGENTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bfs_in_if.sink    in_ch,
    bfs_out_if.source out_ch
);
    import bfs_pkg::*;

    localparam int AW = $clog2(MAX_AGENTS);
    localparam int CW = $clog2(MAX_AGENTS + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    agent_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    agent_t        rd_data;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;

    bfs_store #(
        .MAX_AGENTS (MAX_AGENTS),
        .AW         (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfs_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    bfs_seq #(
        .MAX_AGENTS (MAX_AGENTS),
        .AW         (AW),
        .CW         (CW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

endmodule
